// File: rtl/core/sfh_pkg.sv
`timescale 1ns / 1ps

package sfh_pkg;

    // Fields of a finished name handed from the accumulator to the output stage
    typedef struct packed {
        logic [31:0] hash;   // hash after the leftover bytes are mixed
        logic        empty;  // no byte of the name was taken
    } t_fin;

    // Number of bytes held back between full groups
    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Mix one full group of four bytes, read as two 16-bit halves
    function automatic logic [31:0] mix_group(input logic [31:0] h_in,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, lo};
        t = ({16'd0, hi} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Mix the one to three leftover bytes; nothing to do when none are held
    function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                             input logic [23:0] pend,
                                             input logic [1:0]  cnt);
        logic [31:0] h;
        h = h_in;
        unique case (cnt)
            CNT_ONE: begin
                h = h + {24'd0, pend[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            CNT_TWO: begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            CNT_THREE: begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 16);
                h = h ^ {6'd0, pend[23:16], 18'd0};
                h = h + (h >> 11);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // Six-step final avalanche
    function automatic logic [31:0] avalanche(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

// File: rtl/core/sfh_accum.sv
`timescale 1ns / 1ps

module sfh_accum #(
    parameter int MAX_NAME_LEN = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_name_byte,
    input  logic             i_byte_present,
    input  logic             i_last,
    output logic             o_fin_valid,
    input  logic             i_fin_ready,
    output sfh_pkg::t_fin    o_fin
);

    localparam int TAKEN_W = $clog2(MAX_NAME_LEN + 1);

    logic [31:0]        r_hash,  n_hash,  u_hash;
    logic [23:0]        r_pend,  n_pend,  u_pend;
    logic [1:0]         r_cnt,   n_cnt,   u_cnt;
    logic [TAKEN_W-1:0] r_taken, n_taken, u_taken;
    logic               r_ended, n_ended, u_ended;
    logic               r_fin_valid, n_fin_valid;
    sfh_pkg::t_fin      r_fin,   n_fin;

    logic accept;
    logic take;

    // A request is taken while the finished-name slot is free or draining
    assign o_ready = !r_fin_valid || i_fin_ready;
    assign accept  = i_valid && o_ready;
    assign take    = accept && i_byte_present && !r_ended
                     && (r_taken < TAKEN_W'(MAX_NAME_LEN));

    // Byte gathering and group mixing
    always_comb begin
        u_hash  = r_hash;
        u_pend  = r_pend;
        u_cnt   = r_cnt;
        u_taken = r_taken;
        u_ended = r_ended;
        if (take) begin
            if (i_name_byte == 8'd0) begin
                u_ended = 1'b1;
            end else begin
                u_taken = r_taken + TAKEN_W'(1);
                unique case (r_cnt)
                    sfh_pkg::CNT_NONE: begin
                        u_pend[7:0] = i_name_byte;
                        u_cnt       = sfh_pkg::CNT_ONE;
                    end
                    sfh_pkg::CNT_ONE: begin
                        u_pend[15:8] = i_name_byte;
                        u_cnt        = sfh_pkg::CNT_TWO;
                    end
                    sfh_pkg::CNT_TWO: begin
                        u_pend[23:16] = i_name_byte;
                        u_cnt         = sfh_pkg::CNT_THREE;
                    end
                    default: begin
                        u_hash = sfh_pkg::mix_group(r_hash, r_pend[15:0],
                                                    {i_name_byte, r_pend[23:16]});
                        u_pend = 24'd0;
                        u_cnt  = sfh_pkg::CNT_NONE;
                    end
                endcase
            end
        end
    end

    // Close the name on last: hand over the tail-mixed hash and clear the state
    always_comb begin
        n_hash      = u_hash;
        n_pend      = u_pend;
        n_cnt       = u_cnt;
        n_taken     = u_taken;
        n_ended     = u_ended;
        n_fin       = r_fin;
        n_fin_valid = r_fin_valid && !i_fin_ready;
        if (accept && i_last) begin
            n_fin.hash  = sfh_pkg::tail_mix(u_hash, u_pend, u_cnt);
            n_fin.empty = (u_taken == '0);
            n_fin_valid = 1'b1;
            n_hash      = 32'd0;
            n_pend      = 24'd0;
            n_cnt       = sfh_pkg::CNT_NONE;
            n_taken     = '0;
            n_ended     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= 32'd0;
            r_pend      <= 24'd0;
            r_cnt       <= sfh_pkg::CNT_NONE;
            r_taken     <= '0;
            r_ended     <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            r_hash      <= n_hash;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_taken     <= n_taken;
            r_ended     <= n_ended;
            r_fin_valid <= n_fin_valid;
        end
    end

    // Payload of the finished-name slot
    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

// File: rtl/core/superfasthash_name_hash.sv
`timescale 1ns / 1ps

// 32-bit SuperFastHash of a name streamed one byte per request. A request is
// taken every cycle, the last one of a name included, while the receiver
// keeps up; non-last requests give no result. The hash passes two register
// stages: the edge that takes the last request loads the first, which
// gathers bytes, mixes full groups and mixes the leftover bytes; the second
// is loaded from the first while it is free or draining and applies the
// final avalanche into the output register that drives o_valid. While the
// receiver holds off, one finished hash waits in each stage; once both are
// full the input stalls, non-last requests too, until the receiver takes the
// output. A zero byte ends the name, bytes past MAX_NAME_LEN are dropped, and
// an empty name gives 0. All state clears after each last request, so the
// next name may follow at once.

module superfasthash_name_hash #(
    parameter int MAX_NAME_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_name_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value
);

    sfh_pkg::t_fin fin;
    logic          fin_valid;
    logic          fin_ready;

    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_hash,  n_out_hash;

    sfh_accum #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_name_byte   (i_name_byte),
        .i_byte_present(i_byte_present),
        .i_last        (i_last),
        .o_fin_valid   (fin_valid),
        .i_fin_ready   (fin_ready),
        .o_fin         (fin)
    );

    // Output stage: avalanche into the result register
    assign fin_ready = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_hash  = r_out_hash;
        if (fin_valid && fin_ready) begin
            n_out_valid = 1'b1;
            n_out_hash  = fin.empty ? 32'd0 : sfh_pkg::avalanche(fin.hash);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule
